@@ rtl/tkps_pkg.sv @@
// ----------------------------------------------------------------------------
// Top-k priority selector package
// Shared record type, field widths, operation codes and the ranking function.
// ----------------------------------------------------------------------------
package tkps_pkg;

   // Field widths of one record and of the load counter.
   localparam int RANK_W  = 16;
   localparam int IDENT_W = 27;
   localparam int COUNT_W = 16;

   // Default number of records kept in the chain.
   localparam int MAX_K_DEFAULT = 16;

   // Largest value of the saturating load counter.
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Operation codes of the request channel.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // One stored record with its valid flag.
   typedef struct packed {
      logic               valid;
      logic [RANK_W-1:0]  rank;
      logic [IDENT_W-1:0] ident;
   } slot_type;

   // True when record a ranks strictly above record b: higher priority first,
   // then the smaller code.
   function automatic logic beats(input slot_type a, input slot_type b);
      logic result;
      if (a.rank != b.rank) begin
         result = (a.rank > b.rank);
      end else begin
         result = (a.ident < b.ident);
      end
      return result;
   endfunction

endpackage

@@ rtl/tkps_cell.sv @@
// ----------------------------------------------------------------------------
// Top-k priority selector cell
// One slot of the sorted chain. On an insert it keeps its record, takes the
// new record, or takes the record of its better neighbor.
// ----------------------------------------------------------------------------
module tkps_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              ins_en,
   input  tkps_pkg::slot_type new_rec,
   input  tkps_pkg::slot_type prev_rec,
   input  logic              prev_wins,
   output logic              wins,
   output tkps_pkg::slot_type rec
);
   import tkps_pkg::*;

   logic               valid_ff;
   logic [RANK_W-1:0]  rank_ff;
   logic [IDENT_W-1:0] ident_ff;

   // Present the held record to the neighbor and the read port.
   assign rec = '{valid: valid_ff, rank: rank_ff, ident: ident_ff};

   // The new record belongs at or above this slot when the slot is empty or
   // the new record ranks strictly above it; an equal record goes behind.
   assign wins = !valid_ff || beats(new_rec, rec);

   // The valid flag is control state and is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ins_en) begin
         if (prev_wins) begin
            valid_ff <= prev_rec.valid;
         end else if (wins) begin
            valid_ff <= 1'b1;
         end
      end
   end

   // Record payload: shift down from the neighbor, or take the new record.
   always_ff @(posedge clock) begin
      if (ins_en) begin
         if (prev_wins) begin
            rank_ff  <= prev_rec.rank;
            ident_ff <= prev_rec.ident;
         end else if (wins) begin
            rank_ff  <= new_rec.rank;
            ident_ff <= new_rec.ident;
         end
      end
   end

endmodule

@@ rtl/top_k_priority_selector_top.sv @@
// ----------------------------------------------------------------------------
// Top-k priority selector
// Keeps the MaxK best records in a sorted chain of cells and answers top-k
// queries one result per cycle while the result channel is not stalled.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  req       req_valid/req_stall    req_op, req_rank_value, req_ident,
//                                   req_want_count
//  rsp       rsp_valid/rsp_stall    rsp_out_rank, rsp_out_ident, rsp_last,
//                                   rsp_fault
//
// On a load every cell compares the new record against its own in parallel and
// the chain shifts by one below the insertion point. A good query holds off the
// request channel from its transfer until its last result is registered, one
// result per cycle from the cell read port while the result register is not
// stalled. A bad query gives its single fault result in the next cycle.
// Requests are held off while a query is being emitted or while the result
// register is full and stalled. Reset clears the valid flags and the count.
// ----------------------------------------------------------------------------
module top_k_priority_selector_top #(
   parameter int MaxK = tkps_pkg::MAX_K_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_op,
   input  logic [tkps_pkg::RANK_W-1:0]  req_rank_value,
   input  logic [tkps_pkg::IDENT_W-1:0] req_ident,
   input  logic [tkps_pkg::COUNT_W-1:0] req_want_count,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [tkps_pkg::RANK_W-1:0]  rsp_out_rank,
   output logic [tkps_pkg::IDENT_W-1:0] rsp_out_ident,
   output logic                         rsp_last,
   output logic                         rsp_fault
);
   import tkps_pkg::*;

   localparam int IDX_W = (MaxK > 1) ? $clog2(MaxK) : 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     end_idx_ff, end_idx_in;
   logic [COUNT_W-1:0]   total_ff, total_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RANK_W-1:0]    rsp_rank_ff, rsp_rank_in;
   logic [IDENT_W-1:0]   rsp_ident_ff, rsp_ident_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_fault_ff, rsp_fault_in;

   logic                 req_xfer;
   logic                 out_free;
   logic                 ins_en;
   logic                 bad_k;
   slot_type             new_rec;
   slot_type             rec   [MaxK];
   logic                 wins  [MaxK];
   slot_type             rd_rec;

   // The result register can take a new entry when empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff == ST_EMIT) || !out_free;
   assign req_xfer  = req_valid && !req_stall;
   assign ins_en    = req_xfer && (req_op == OP_LOAD);
   assign new_rec   = '{valid: 1'b1, rank: req_rank_value, ident: req_ident};

   // A query is refused when k is zero, beyond the chain, or beyond the count.
   assign bad_k = (req_want_count == '0) ||
                  (req_want_count > COUNT_W'(MaxK)) ||
                  (req_want_count > total_ff);

   // Sorted chain of cells; cell 0 holds the best record.
   for (genvar i = 0; i < MaxK; i++) begin : g_cell
      if (i == 0) begin : g_head
         tkps_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ins_en    (ins_en),
            .new_rec   (new_rec),
            .prev_rec  ('0),
            .prev_wins (1'b0),
            .wins      (wins[i]),
            .rec       (rec[i])
         );
      end else begin : g_body
         tkps_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ins_en    (ins_en),
            .new_rec   (new_rec),
            .prev_rec  (rec[i-1]),
            .prev_wins (wins[i-1]),
            .wins      (wins[i]),
            .rec       (rec[i])
         );
      end
   end

   // Read port for the query emitter.
   assign rd_rec = rec[idx_ff];

   // Query sequencer, load counter and result register.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      end_idx_in   = end_idx_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_rank_in  = rsp_rank_ff;
      rsp_ident_in = rsp_ident_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_fault_in = rsp_fault_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_op == OP_LOAD) begin
                  if (total_ff != COUNT_MAX) begin
                     total_in = total_ff + 1'b1;
                  end
               end else if (bad_k) begin
                  rsp_valid_in = 1'b1;
                  rsp_rank_in  = '0;
                  rsp_ident_in = '0;
                  rsp_last_in  = 1'b1;
                  rsp_fault_in = 1'b1;
               end else begin
                  state_in   = ST_EMIT;
                  idx_in     = '0;
                  end_idx_in = IDX_W'(req_want_count - 1'b1);
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rank_in  = rd_rec.rank;
               rsp_ident_in = rd_rec.ident;
               rsp_last_in  = (idx_ff == end_idx_ff);
               rsp_fault_in = 1'b0;
               if (idx_ff == end_idx_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Index and result payload registers.
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      end_idx_ff   <= end_idx_in;
      rsp_rank_ff  <= rsp_rank_in;
      rsp_ident_ff <= rsp_ident_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_rank  = rsp_rank_ff;
   assign rsp_out_ident = rsp_ident_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_fault     = rsp_fault_ff;

endmodule
